// ===== rtl/core/srd_pkg.sv =====
// Package: shared types and constants for the sensor record deframer.
package srd_pkg;

  // Framing bytes
  localparam logic [7:0] SYNC_A    = 8'h23;  // '#'
  localparam logic [7:0] SYNC_B    = 8'h21;  // '!'
  localparam logic [7:0] TAG_ERR   = 8'h45;  // 'E'
  localparam logic [7:0] TAG_RANGE = 8'h52;  // 'R'
  localparam logic [7:0] TAG_IMU   = 8'h49;  // 'I'

  // Entry kinds
  localparam logic [1:0] KIND_ERR   = 2'd0;
  localparam logic [1:0] KIND_RANGE = 2'd1;
  localparam logic [1:0] KIND_IMU   = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  // Entry lengths in bytes
  localparam logic [4:0] LEN_ERR   = 5'd2;
  localparam logic [4:0] LEN_RANGE = 5'd10;
  localparam logic [4:0] LEN_IMU   = 5'd20;

  // Bytes held before the completing byte of the longest entry
  localparam int unsigned STORE_DEPTH = 19;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  typedef struct packed {
    logic [1:0]         entry_kind;
    logic signed [15:0] error_code;
    logic [15:0]        range_value;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [63:0]        timestamp;
  } result_t;

  function automatic logic [4:0] entry_len(input logic [1:0] kind);
    logic [4:0] len;
    case (kind)
      KIND_ERR:   len = LEN_ERR;
      KIND_RANGE: len = LEN_RANGE;
      default:    len = LEN_IMU;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/srd_if.sv =====
// Interfaces: byte input channel and entry result channel.
interface srd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface srd_out_if import srd_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t res;

  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

// ===== rtl/core/srd_parser.sv =====
// Parser: sync hunt, record state machine and entry byte store.
module srd_parser import srd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  output logic       emit,
  output result_t    result
);

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_TAG   = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;
  localparam logic [1:0] PH_ENTRY = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] old_b_r, old_b_nxt, new_b_r, new_b_nxt;
  logic       old_v_r, old_v_nxt, new_v_r, new_v_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] left_r, left_nxt;
  logic [4:0] pos_r, pos_nxt;

  logic [7:0] bytes_r [STORE_DEPTH];
  logic                st_we;
  logic [STORE_AW-1:0] st_idx;

  logic [4:0] len;
  logic [4:0] pos_eff;

  // Next state for one byte
  always_comb begin
    phase_nxt = phase_r;
    old_b_nxt = old_b_r;
    old_v_nxt = old_v_r;
    new_b_nxt = new_b_r;
    new_v_nxt = new_v_r;
    kind_nxt  = kind_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    st_we     = 1'b0;
    st_idx    = '0;
    emit      = 1'b0;
    len       = entry_len(kind_r);
    pos_eff   = (pos_r >= len) ? 5'd0 : pos_r;

    unique case (phase_r)
      PH_TAG: begin
        if (data_byte == TAG_ERR) begin
          kind_nxt  = KIND_ERR;
          phase_nxt = PH_COUNT;
        end else if (data_byte == TAG_RANGE) begin
          kind_nxt  = KIND_RANGE;
          phase_nxt = PH_COUNT;
        end else if (data_byte == TAG_IMU) begin
          kind_nxt  = KIND_IMU;
          phase_nxt = PH_COUNT;
        end else begin
          // reuse the unknown tag as the first hunt byte
          phase_nxt = PH_HUNT;
          new_b_nxt = data_byte;
          new_v_nxt = 1'b1;
          old_v_nxt = 1'b0;
        end
      end
      PH_COUNT: begin
        left_nxt  = data_byte;
        pos_nxt   = 5'd0;
        phase_nxt = (data_byte == 8'd0) ? PH_TAG : PH_ENTRY;
      end
      PH_ENTRY: begin
        if (kind_r == KIND_BAD) begin
          phase_nxt = PH_HUNT;
          old_v_nxt = 1'b0;
          new_v_nxt = 1'b0;
        end else if (pos_eff + 5'd1 < len) begin
          // hold the byte until the entry completes
          st_we   = 1'b1;
          st_idx  = pos_eff[STORE_AW-1:0];
          pos_nxt = pos_eff + 5'd1;
        end else begin
          emit     = 1'b1;
          pos_nxt  = 5'd0;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            phase_nxt = PH_TAG;
          end
        end
      end
      default: begin
        // slide the three-byte sync window
        if (old_v_r && new_v_r && old_b_r == SYNC_A && new_b_r == SYNC_B) begin
          old_v_nxt = 1'b0;
          new_v_nxt = 1'b0;
          old_b_nxt = 8'd0;
          new_b_nxt = 8'd0;
          if (data_byte != 8'd0 && !data_byte[7]) begin
            phase_nxt = PH_TAG;
          end
        end else begin
          old_b_nxt = new_b_r;
          old_v_nxt = new_v_r;
          new_b_nxt = data_byte;
          new_v_nxt = 1'b1;
        end
      end
    endcase
  end

  // Assemble the result from held bytes and the completing byte
  always_comb begin
    result            = '0;
    result.entry_kind = kind_r;
    case (kind_r)
      KIND_ERR: begin
        result.error_code = {bytes_r[0], data_byte};
      end
      KIND_RANGE: begin
        result.range_value = {bytes_r[0], bytes_r[1]};
        result.timestamp   = {bytes_r[2], bytes_r[3], bytes_r[4], bytes_r[5],
                              bytes_r[6], bytes_r[7], bytes_r[8], data_byte};
      end
      default: begin
        result.gyro_x    = {bytes_r[0], bytes_r[1]};
        result.gyro_y    = {bytes_r[2], bytes_r[3]};
        result.gyro_z    = {bytes_r[4], bytes_r[5]};
        result.accel_x   = {bytes_r[6], bytes_r[7]};
        result.accel_y   = {bytes_r[8], bytes_r[9]};
        result.accel_z   = {bytes_r[10], bytes_r[11]};
        result.timestamp = {bytes_r[12], bytes_r[13], bytes_r[14], bytes_r[15],
                            bytes_r[16], bytes_r[17], bytes_r[18], data_byte};
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      old_b_r <= 8'd0;
      old_v_r <= 1'b0;
      new_b_r <= 8'd0;
      new_v_r <= 1'b0;
      kind_r  <= KIND_ERR;
      left_r  <= 8'd0;
      pos_r   <= 5'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      old_b_r <= old_b_nxt;
      old_v_r <= old_v_nxt;
      new_b_r <= new_b_nxt;
      new_v_r <= new_v_nxt;
      kind_r  <= kind_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Entry byte store
  always_ff @(posedge clk) begin
    if (step && st_we) begin
      bytes_r[st_idx] <= data_byte;
    end
  end

  // A full inertial entry holds every store slot before its last byte
  a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < LEN_IMU)
    else $error("entry byte position beyond store");

  a_entry_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ENTRY |-> left_r != 8'd0)
    else $error("inside an entry with no entries left");

  a_emit_known_kind: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> phase_r == PH_ENTRY && kind_r != KIND_BAD)
    else $error("result raised outside a valid entry");

endmodule

// ===== rtl/core/sensor_record_deframer.sv =====
// Top level: sensor record deframer with input buffer and result register.
// Takes one serial byte per cycle while out_ch keeps up, hunts for the
// '#','!',length sync header, then parses tagged records of error, range
// and inertial entries and emits one result per completed entry. The
// parser's per-byte state machine sustains one byte per clock unless the
// result side stalls. Each byte is held in the input register; the result
// of a completed entry is registered in the result register. One byte is
// buffered at the input, so the block can take one more byte while a finished
// result waits for out_ch.ready; it stops only when both of them stall.
module sensor_record_deframer import srd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  srd_in_if.sink    in_ch,
  srd_out_if.source out_ch
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       emit;
  result_t    result;
  logic       out_valid_r;
  result_t    out_res_r;

  // Process the buffered byte when the result register is free or being taken
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.data_byte;
    end
  end

  srd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .emit      (emit),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.res   = out_res_r;

  a_advance_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> in_valid_r)
    else $error("parser stepped without a buffered byte");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit |=> out_valid_r)
    else $error("completed entry did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !advance)
    else $error("pending result overwritten");

endmodule

// ===== bench/srd_entry_checker.sv =====
// Entry checker: predicts deframed entries from accepted bytes and compares results.
module srd_entry_checker import srd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  srd_in_if    in_ch,
  srd_out_if   out_ch,
  output int   error_count,
  output int   entries_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_TAG,
    PH_COUNT,
    PH_ENTRY
  } parse_phase_e;

  // Parser state as the block should hold it
  parse_phase_e phase;
  logic         older_ok;
  logic         newer_ok;
  logic [7:0]   older_byte;
  logic [7:0]   newer_byte;
  logic [1:0]   rec_kind;
  logic [7:0]   entries_left;
  int           byte_pos;
  logic [7:0]   held [0:19];

  result_t expected_entries[$];

  // Advance the parser by one byte; flag a finished entry and return it
  task automatic deframe_byte(input logic [7:0] x, output bit done, output result_t r);
    int          len;
    logic [63:0] ts;
    done = 1'b0;
    r    = '0;
    ts   = '0;
    case (phase)
      PH_TAG: begin
        if (x == TAG_ERR || x == TAG_RANGE || x == TAG_IMU) begin
          rec_kind = (x == TAG_ERR) ? KIND_ERR : (x == TAG_RANGE) ? KIND_RANGE : KIND_IMU;
          phase    = PH_COUNT;
        end else begin
          // unknown tag: back to hunting, the byte starts the new window
          phase      = PH_HUNT;
          older_ok   = 1'b0;
          newer_ok   = 1'b1;
          newer_byte = x;
        end
      end
      PH_COUNT: begin
        entries_left = x;
        byte_pos     = 0;
        phase        = (x == 8'd0) ? PH_TAG : PH_ENTRY;
      end
      PH_ENTRY: begin
        case (rec_kind)
          KIND_ERR:   len = LEN_ERR;
          KIND_RANGE: len = LEN_RANGE;
          default:    len = LEN_IMU;
        endcase
        if (byte_pos + 1 < len) begin
          held[byte_pos] = x;
          byte_pos++;
        end else begin
          held[len-1]  = x;
          r.entry_kind = rec_kind;
          if (rec_kind == KIND_ERR) begin
            r.error_code = {held[0], held[1]};
          end else if (rec_kind == KIND_RANGE) begin
            r.range_value = {held[0], held[1]};
            for (int k = 0; k < 8; k++) ts = {ts[55:0], held[2+k]};
            r.timestamp = ts;
          end else begin
            r.gyro_x  = {held[0], held[1]};
            r.gyro_y  = {held[2], held[3]};
            r.gyro_z  = {held[4], held[5]};
            r.accel_x = {held[6], held[7]};
            r.accel_y = {held[8], held[9]};
            r.accel_z = {held[10], held[11]};
            for (int k = 0; k < 8; k++) ts = {ts[55:0], held[12+k]};
            r.timestamp = ts;
          end
          byte_pos     = 0;
          entries_left = entries_left - 8'd1;
          if (entries_left == 8'd0) phase = PH_TAG;
          done = 1'b1;
        end
      end
      default: begin
        // hunt: look for '#','!' in the held pair, then judge the length byte
        if (older_ok && newer_ok && older_byte == SYNC_A && newer_byte == SYNC_B) begin
          older_ok = 1'b0;
          newer_ok = 1'b0;
          if (x >= 8'd1 && x <= 8'd127) phase = PH_TAG;
        end else begin
          older_ok   = newer_ok;
          older_byte = newer_byte;
          newer_ok   = 1'b1;
          newer_byte = x;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] seen);
    if (want !== seen) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
    end
  endtask

  // Compare each handed-over result, then predict from each accepted request
  always @(posedge clk) begin
    result_t want;
    result_t seen;
    bit      done;
    if (!rst_n) begin
      phase        = PH_HUNT;
      older_ok     = 1'b0;
      newer_ok     = 1'b0;
      older_byte   = '0;
      newer_byte   = '0;
      rec_kind     = KIND_ERR;
      entries_left = '0;
      byte_pos     = 0;
      expected_entries.delete();
      error_count  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = out_ch.res;
        if (expected_entries.size() == 0) begin
          error_count++;
          $display("%0t: unexpected entry, expected none, actual %p", $time, seen);
        end else begin
          want = expected_entries.pop_front();
          check_field("entry_kind", want.entry_kind, seen.entry_kind);
          check_field("error_code", want.error_code, seen.error_code);
          check_field("range_value", want.range_value, seen.range_value);
          check_field("gyro_x", want.gyro_x, seen.gyro_x);
          check_field("gyro_y", want.gyro_y, seen.gyro_y);
          check_field("gyro_z", want.gyro_z, seen.gyro_z);
          check_field("accel_x", want.accel_x, seen.accel_x);
          check_field("accel_y", want.accel_y, seen.accel_y);
          check_field("accel_z", want.accel_z, seen.accel_z);
          check_field("timestamp", want.timestamp, seen.timestamp);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.data_byte, done, want);
        if (done) expected_entries.push_back(want);
      end
    end
    entries_waiting = expected_entries.size();
  end

endmodule

// ===== bench/sensor_record_deframer_tb.sv =====
// Testbench top: byte stimulus, result back-pressure and the final verdict.
module sensor_record_deframer_tb import srd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   entries_waiting;

  srd_in_if  in_ch ();
  srd_out_if out_ch ();

  sensor_record_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  srd_entry_checker entry_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .error_count     (fail_count),
    .entries_waiting (entries_waiting)
  );

  int         bytes_sent;
  int         sender_calm;
  int         frame_no;
  bit         long_record_done;
  bit         paused_once;
  logic [7:0] frame_q[$];
  logic [7:0] opening_q[$];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Payload bytes lean toward the field extremes
  function automatic logic [7:0] field_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      2:       b = 8'h80;
      3:       b = 8'h7F;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Offer one byte after a random gap and hold it until it is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (sender_calm > 0) begin
      gap = 0;
      sender_calm--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) sender_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Build one sync frame with a few records of random content
  task automatic build_frame();
    logic [7:0] tag;
    logic [7:0] b;
    int         len;
    int         cnt;
    frame_q.delete();
    repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
    frame_q.push_back(SYNC_A);
    frame_q.push_back(SYNC_B);
    if ($urandom_range(0, 6) == 0) begin
      // bad length: zero or negative
      frame_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(128, 255)));
      return;
    end
    frame_q.push_back(8'($urandom_range(1, 127)));
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 2))
        0: begin
          tag = TAG_ERR;
          len = LEN_ERR;
        end
        1: begin
          tag = TAG_RANGE;
          len = LEN_RANGE;
        end
        default: begin
          tag = TAG_IMU;
          len = LEN_IMU;
        end
      endcase
      cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      // one record with the largest count
      if (!long_record_done && frame_no >= 4) begin
        tag = TAG_ERR;
        len = LEN_ERR;
        cnt = 255;
        long_record_done = 1'b1;
      end
      frame_q.push_back(tag);
      frame_q.push_back(8'(cnt));
      repeat (cnt * len) frame_q.push_back(field_byte());
    end
    // close the frame with an unknown tag now and then
    if ($urandom_range(0, 1) == 1) begin
      do b = 8'($urandom_range(0, 255));
      while (b == TAG_ERR || b == TAG_RANGE || b == TAG_IMU);
      frame_q.push_back(b);
    end
  endtask

  // Result side: stall a random number of cycles before each result
  initial begin
    int stall;
    int calm;
    calm = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (calm > 0) begin
        stall = 0;
        calm--;
      end else begin
        stall = $urandom_range(0, 5);
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    rst_n            = 1'b0;
    bytes_sent       = 0;
    sender_calm      = 0;
    frame_no         = 0;
    long_record_done = 1'b0;
    paused_once      = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    opening_q = '{
      SYNC_A, SYNC_B, 8'h00,          // zero length is used up
      SYNC_A, SYNC_B, 8'h80,          // negative length is used up
      SYNC_A, SYNC_A, SYNC_B, 8'h01,  // window slides onto the pair, shortest length
      TAG_ERR, 8'h00,                 // zero count: next byte is a tag
      TAG_ERR, 8'h01, 8'h80, 8'h00,   // most negative error code
      SYNC_A, SYNC_B, 8'h7F,          // unknown tag reused as first hunt byte
      TAG_IMU, 8'h00,
      8'h51                           // unknown tag drops back to hunting
    };
    foreach (opening_q[i]) send_byte(opening_q[i]);

    // hold off until every expected entry has come
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (entries_waiting != 0) @(negedge clk);

    while (bytes_sent < 1550) begin
      frame_no++;
      build_frame();
      if ($urandom_range(0, 4) == 0) begin
        // cut the frame short
        while (frame_q.size() > $urandom_range(1, frame_q.size())) void'(frame_q.pop_back());
      end else if ($urandom_range(0, 9) == 0) begin
        // plain noise, rich in sync bytes
        frame_q.delete();
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 2))
            0:       frame_q.push_back(SYNC_A);
            1:       frame_q.push_back(SYNC_B);
            default: frame_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      foreach (frame_q[i]) send_byte(frame_q[i]);
      if (!paused_once && bytes_sent > 700) begin
        paused_once = 1'b1;
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (entries_waiting != 0) @(negedge clk);
      end
    end

    // drain the block
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (entries_waiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (fail_count == 0) begin
      $display("** sensor_record_deframer: PASSED **");
    end else begin
      $display("** sensor_record_deframer: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("** sensor_record_deframer: FAILED **");
    $finish;
  end

endmodule
